/* rtl/udf_pkg.sv */
// Shared types and constants for the serial frame deframer.
// Depends on nothing; imported by udf_ctrl, udf_dpath and the top level.
package udf_pkg;

  localparam int unsigned POINTS    = 47;
  localparam int unsigned FRAME_LEN = 2 * POINTS + 5;
  localparam int unsigned FILL_W    = $clog2(FRAME_LEN);
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned OUT_W     = 24;  // index and value, padded to whole bytes

  localparam logic [7:0] HDR0 = 8'hAA;
  localparam logic [7:0] HDR1 = 8'h55;
  localparam logic [7:0] TRL0 = 8'h0D;
  localparam logic [7:0] TRL1 = 8'h0A;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic shift_in;  // push received byte into the window
    logic fill_clr;  // window consumed, restart fill and point count
    logic emit;      // load next point into output register, rotate window by two
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic window_full;  // window holds FRAME_LEN-1 bytes; next byte completes it
    logic frame_ok;     // header, trailer and checksum all match
    logic out_free;     // output register can take a point this cycle
    logic last_point;   // point counter at the final point
  } stat_t;

endpackage

/* rtl/udf_ctrl.sv */
// Controller state machine for the frame deframer.
// Depends on udf_pkg; drives udf_dpath through cmd_t and reads stat_t.
module udf_ctrl
  import udf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift_in = 1'b1;
          if (stat_i.window_full) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (stat_i.frame_ok) begin
          cmd_o.fill_clr = 1'b1;
          state_d        = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_point) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/udf_dpath.sv */
// Datapath of the frame deframer: byte window shift line, running checksum,
// fill and point counters, output register. Depends on udf_pkg.
module udf_dpath
  import udf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       rx_byte_i,
  input  cmd_t             cmd_i,
  output stat_t            stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] out_data_o,
  output logic             out_last_o
);

  // Index 0 is the newest byte, FRAME_LEN-1 the oldest (first header byte).
  localparam int unsigned DATA_HI = FRAME_LEN - 3;  // low byte of point 0
  localparam int unsigned CSUM    = 2;

  logic [7:0]        win_q [FRAME_LEN];
  logic [7:0]        win_d [FRAME_LEN];
  logic [7:0]        sum_q, sum_d;      // sum of taps DATA_HI down to 3
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]  pt_q, pt_d;
  logic              out_vld_q, out_vld_d;
  logic [IDX_W-1:0]  out_idx_q;
  logic [VAL_W-1:0]  out_val_q;
  logic              out_last_q;

  always_comb begin
    for (int i = 0; i < FRAME_LEN; i++) begin
      win_d[i] = win_q[i];
    end
    sum_d = sum_q;
    if (cmd_i.shift_in) begin
      win_d[0] = rx_byte_i;
      for (int i = 1; i < FRAME_LEN; i++) begin
        win_d[i] = win_q[i-1];
      end
      sum_d = sum_q + win_q[CSUM] - win_q[DATA_HI];
    end else if (cmd_i.emit) begin
      // rotate by two so the next point lands on the fixed read taps
      win_d[0] = win_q[FRAME_LEN-2];
      win_d[1] = win_q[FRAME_LEN-1];
      for (int i = 2; i < FRAME_LEN; i++) begin
        win_d[i] = win_q[i-2];
      end
      sum_d = sum_q + win_q[CSUM] + win_q[CSUM-1] - win_q[DATA_HI] - win_q[DATA_HI-1];
    end
  end

  always_comb begin
    fill_d = fill_q;
    pt_d   = pt_q;
    if (cmd_i.fill_clr) begin
      fill_d = '0;
      pt_d   = '0;
    end else begin
      if (cmd_i.shift_in && !stat_o.window_full) begin
        fill_d = fill_q + FILL_W'(1);
      end
      if (cmd_i.emit) begin
        pt_d = pt_q + IDX_W'(1);
      end
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (cmd_i.emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  // Window and sum are reset so the running sum always matches the taps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_q[i] <= '0;
      end
      sum_q     <= '0;
      fill_q    <= '0;
      pt_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      for (int i = 0; i < FRAME_LEN; i++) begin
        win_q[i] <= win_d[i];
      end
      sum_q     <= sum_d;
      fill_q    <= fill_d;
      pt_q      <= pt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_idx_q  <= pt_q;
      out_val_q  <= {win_q[DATA_HI-1], win_q[DATA_HI]};
      out_last_q <= stat_o.last_point;
    end
  end

  always_comb begin
    stat_o.window_full = (fill_q == FILL_W'(FRAME_LEN - 1));
    stat_o.frame_ok    = (win_q[FRAME_LEN-1] == HDR0) && (win_q[FRAME_LEN-2] == HDR1)
                      && (win_q[1] == TRL0) && (win_q[0] == TRL1)
                      && (win_q[CSUM] == sum_q);
    stat_o.out_free    = !out_vld_q || out_ready_i;
    stat_o.last_point  = (pt_q == IDX_W'(POINTS - 1));
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = {{(OUT_W - IDX_W - VAL_W){1'b0}}, out_val_q, out_idx_q};
  assign out_last_o  = out_last_q;

endmodule

/* rtl/uart_matrix_frame_deframer.sv */
// Serial frame deframer: finds AA 55, POINTS 16-bit values, checksum, 0D 0A.
// Throughput: one byte per cycle while the window fills; a byte that completes
// the window is followed by the frame check, during which no byte is taken. A valid frame
// then streams POINTS items, one per cycle when the sink is ready, via the output register.
// The first item is registered in the emit state, which follows the check state.
// Reset (async, rst_ni low): window, checksum, counters and output valid cleared; no clearing pass.
module uart_matrix_frame_deframer
  import udf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // byte input
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [7:0]       s_axis_tdata_i,   // [7:0] rx_byte
  // point output
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [OUT_W-1:0] m_axis_tdata_o,   // [5:0] point_index, [21:6] point_value, [23:22] zero
  output logic             m_axis_tlast_o    // frame_last
);

  // The window is a shift line of FRAME_LEN bytes with the oldest byte at the
  // top. Header, trailer and checksum sit on fixed taps; the data sum is kept
  // incrementally as bytes enter and leave the data region, so each candidate
  // start is judged combinationally from the taps. On a valid frame the window rotates two
  // bytes per item so each point is read from the same pair of taps.

  cmd_t  cmd;
  stat_t stat;

  udf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  udf_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (s_axis_tdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (m_axis_tdata_o),
    .out_last_o  (m_axis_tlast_o)
  );

endmodule

/* bench/tb_uart_matrix_frame_deframer.sv */
`timescale 1ns / 100ps
// Self-checking bench for uart_matrix_frame_deframer: byte stream in, frame points out.
// Depends on udf_pkg and the deframer RTL; the scoreboard class holds its own window model.

module tb_uart_matrix_frame_deframer;
  import udf_pkg::*;

  localparam int unsigned LIMIT  = 400000;  // cycles before the run is called hung
  localparam int unsigned DRAIN  = 20;      // settle time once nothing is due
  localparam int unsigned ITEMS  = 430;     // bytes in the whole run
  localparam int unsigned IDLE_P = 32;      // idle chance per cycle, in percent

  // ways a frame can be spoilt before it is sent
  typedef enum int unsigned {
    FLAW_NONE,
    FLAW_HDR0,
    FLAW_HDR1,
    FLAW_SUM,
    FLAW_TRL0,
    FLAW_TRL1,
    FLAW_DATA
  } flaw_e;

  // patterns for the point values of a frame
  typedef enum int unsigned {
    VALS_ZERO,
    VALS_ONES,
    VALS_HDRLIKE,
    VALS_RANDOM
  } vals_e;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
    logic             last;
  } point_t;

  // Tracks the byte window as the block should, and queues the points each
  // accepted byte is owed.
  class point_ledger;
    logic [7:0]  window[];
    int unsigned fill;
    int unsigned head;
    int unsigned faults;
    point_t      points_due[$];

    function new();
      window = new[FRAME_LEN];
      fill   = 0;
      head   = 0;
      faults = 0;
    endfunction

    function logic [7:0] at(int unsigned k);
      return window[(head + k) % FRAME_LEN];
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0]  sum;
      int unsigned k;
      point_t      p;
      bit          good;
      window[(head + fill) % FRAME_LEN] = b;
      fill++;
      if (fill < FRAME_LEN) return;
      sum = '0;
      for (k = 0; k < 2 * POINTS; k++) sum += at(2 + k);
      good = at(0) == HDR0 && at(1) == HDR1 &&
             at(FRAME_LEN - 2) == TRL0 && at(FRAME_LEN - 1) == TRL1 &&
             sum == at(2 * POINTS + 2);
      if (!good) begin
        // drop the oldest byte, next byte completes the next candidate
        head = (head + 1) % FRAME_LEN;
        fill = FRAME_LEN - 1;
        return;
      end
      for (k = 0; k < POINTS; k++) begin
        p.index = k[IDX_W-1:0];
        p.value = {at(3 + 2 * k), at(2 + 2 * k)};
        p.last  = (k == POINTS - 1);
        points_due.push_back(p);
      end
      fill = 0;
      head = 0;
    endfunction

    function void match_point(logic [OUT_W-1:0] data, logic last_bit);
      point_t want;
      if (points_due.size() == 0) begin
        $error("point with no frame behind it: point_index %0d", data[IDX_W-1:0]);
        faults++;
        return;
      end
      want = points_due.pop_front();
      if (data[IDX_W-1:0] !== want.index) begin
        $error("point_index: expected %0d, got %0d", want.index, data[IDX_W-1:0]);
        faults++;
      end
      if (data[IDX_W+VAL_W-1:IDX_W] !== want.value) begin
        $error("point_value: expected %h, got %h", want.value, data[IDX_W+VAL_W-1:IDX_W]);
        faults++;
      end
      if (data[OUT_W-1:IDX_W+VAL_W] !== '0) begin
        $error("tdata padding: expected 0, got %b", data[OUT_W-1:IDX_W+VAL_W]);
        faults++;
      end
      if (last_bit !== want.last) begin
        $error("frame_last: expected %0b, got %0b", want.last, last_bit);
        faults++;
      end
    endfunction
  endclass

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             s_valid = 1'b0;
  logic [7:0]       s_data  = '0;
  logic             m_ready = 1'b0;
  logic             s_axis_tready_o;
  logic             m_axis_tvalid_o;
  logic [OUT_W-1:0] m_axis_tdata_o;
  logic             m_axis_tlast_o;

  bit               steady = 1'b0;  // both sides run without gaps while set
  int unsigned      items_sent = 0;
  int unsigned      cycle_cnt = 0;
  logic [15:0]      frame_vals [POINTS];
  point_ledger      ledger;

  uart_matrix_frame_deframer u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // sink: random back-pressure, set at the falling edge
  always @(negedge clk_i) m_ready = steady || ($urandom_range(99) >= IDLE_P);

  // results are taken at the rising edge, before the block's registers move
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) ledger.match_point(m_axis_tdata_o, m_axis_tlast_o);
  end

  // Offer one byte; entered and left at a falling edge. A random gap may come first.
  task automatic push_byte(input logic [7:0] b);
    while (!steady && $urandom_range(99) < IDLE_P) begin
      s_valid = 1'b0;
      @(negedge clk_i);
    end
    s_valid = 1'b1;
    s_data  = b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    ledger.take_byte(b);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic fill_vals(input vals_e mode);
    int unsigned k;
    for (k = 0; k < POINTS; k++) begin
      case (mode)
        VALS_ZERO:    frame_vals[k] = 16'h0000;
        VALS_ONES:    frame_vals[k] = 16'hFFFF;
        // data that looks like header and trailer bytes
        VALS_HDRLIKE: frame_vals[k] = (k % 2 == 0) ? {HDR1, HDR0} : {TRL1, TRL0};
        default: begin
          case ($urandom_range(9))
            0:       frame_vals[k] = {HDR1, HDR0};
            1:       frame_vals[k] = 16'hFFFF;
            2:       frame_vals[k] = 16'h0000;
            default: frame_vals[k] = 16'($urandom);
          endcase
        end
      endcase
    end
  endtask

  // Build a frame from frame_vals, spoil it as asked, send its first cut bytes.
  task automatic send_frame(input flaw_e flaw, input int unsigned cut);
    logic [7:0]  frame_bytes [FRAME_LEN];
    logic [7:0]  sum;
    logic [7:0]  flip;
    int unsigned k;
    sum = '0;
    frame_bytes[0] = HDR0;
    frame_bytes[1] = HDR1;
    for (k = 0; k < POINTS; k++) begin
      frame_bytes[2 + 2 * k] = frame_vals[k][7:0];
      frame_bytes[3 + 2 * k] = frame_vals[k][15:8];
      sum += frame_vals[k][7:0] + frame_vals[k][15:8];
    end
    frame_bytes[FRAME_LEN - 3] = sum;
    frame_bytes[FRAME_LEN - 2] = TRL0;
    frame_bytes[FRAME_LEN - 1] = TRL1;
    // non-zero flip always breaks the byte, and for data bytes the checksum too
    flip = 8'($urandom_range(255, 1));
    case (flaw)
      FLAW_HDR0: frame_bytes[0] ^= flip;
      FLAW_HDR1: frame_bytes[1] ^= flip;
      FLAW_SUM:  frame_bytes[FRAME_LEN - 3] ^= flip;
      FLAW_TRL0: frame_bytes[FRAME_LEN - 2] ^= flip;
      FLAW_TRL1: frame_bytes[FRAME_LEN - 1] ^= flip;
      FLAW_DATA: frame_bytes[2 + $urandom_range(2 * POINTS - 1)] ^= flip;
      default: ;
    endcase
    for (k = 0; k < cut; k++) push_byte(frame_bytes[k]);
  endtask

  initial begin
    int unsigned target;
    int unsigned round;
    int unsigned pick;
    int unsigned room;
    ledger = new();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: leading noise with a stray header byte
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(HDR0);
    // all-zero frame with no gaps on either side
    steady = 1'b1;
    fill_vals(VALS_ZERO);
    send_frame(FLAW_NONE, FRAME_LEN);
    steady = 1'b0;
    // all-ones frame, checksum wraps many times
    fill_vals(VALS_ONES);
    send_frame(FLAW_NONE, FRAME_LEN);
    // bad header cut short over data full of false headers; the good frame
    // after it is found once the window has slid past them
    fill_vals(VALS_HDRLIKE);
    send_frame(FLAW_HDR1, 12);
    fill_vals(VALS_RANDOM);
    send_frame(FLAW_NONE, FRAME_LEN);
    // bad checksum
    fill_vals(VALS_RANDOM);
    send_frame(FLAW_SUM, FRAME_LEN);

    // random up to the byte budget: good, spoilt, cut short and noise
    target = ITEMS;
    round  = 0;
    while (items_sent < target) begin
      room   = target - items_sent;
      if (room > FRAME_LEN) room = FRAME_LEN;
      steady = (round == 2 || round == 3);
      pick   = $urandom_range(99);
      fill_vals(VALS_RANDOM);
      if (pick < 55) send_frame(FLAW_NONE, room);
      else if (pick < 80) send_frame(flaw_e'($urandom_range(FLAW_DATA, FLAW_HDR0)), room);
      else if (pick < 90) begin
        send_frame(FLAW_NONE, $urandom_range((room < FRAME_LEN) ? room : FRAME_LEN - 1, 1));
      end else repeat ($urandom_range((room < 12) ? room : 12, 1)) push_byte(8'($urandom));
      round++;
    end
    steady  = 1'b0;
    s_valid = 1'b0;

    while (ledger.points_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
    if (ledger.faults == 0 && ledger.points_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
